// ----- rtl/core/centered_moving_average_assert.svh -----
// Assertion macros for the centered moving average block.
`ifndef CENTERED_MOVING_AVERAGE_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("centered moving average check failed");

// The consequent must hold in the cycle after the antecedent.
`define CMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("centered moving average check failed");

`else

`define CMA_ASSERT_NOW(label, ante, cons)
`define CMA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/cma_pkg.sv -----
// Shared constants and request types of the centered moving average block.
`default_nettype none

package cma_pkg;

  localparam int MAX_HALF_WINDOW = 8;
  localparam int SAMPLE_BITS     = 32;
  localparam int CFG_W           = 4;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          is_last;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean;
    logic                          out_last;
  } out_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/centered_moving_average.sv -----
// Top level of the centered moving average block with truncated series edges.
`default_nettype none

// Centered moving average over a series of signed Q16.16 samples. Each result
// is the mean of the samples within half_window positions on either side of
// one series position; near both ends of the series only the samples present
// are summed and the divisor is their count, and the quotient is truncated
// toward zero. Results lag the input by half_window requests, and the request
// flagged is_last flushes every pending position, the final one with out_last
// set; the next request starts a new series. half_window is written through
// the cfg port while the block is idle, and values above MAX_HALF_WINDOW act
// as MAX_HALF_WINDOW. The block handles one input request at a time and holds
// in_stall high until all results it causes have been taken. Each result is
// built by a small sequencer around one shared adder and one bit-serial
// restoring divider. In order, it decides for the first result of a request,
// sums the samples of the window one by one (at most 2*MAX_HALF_WINDOW+1 of
// them), takes the magnitude, runs the divider, restores the sign, waits on
// the output handshake and picks the next position. An ordinary request
// causes at most one result, and the request that ends a series causes up
// to half_window+1 results.
module centered_moving_average #(
  parameter int MAX_HALF_WINDOW = cma_pkg::MAX_HALF_WINDOW
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  cma_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  wire                           out_stall,
  output cma_pkg::out_req_t             out_req,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [cma_pkg::CFG_W-1:0]     cfg_data
);

  import cma_pkg::*;

  `include "centered_moving_average_assert.svh"

  // History depth, index and count widths all follow from the window limit.
  localparam int HIST   = 2 * MAX_HALF_WINDOW + 1;
  localparam int IDX_W  = $clog2(HIST);
  localparam int CNT_W  = $clog2(HIST + 1);
  localparam int H_W    = $clog2(MAX_HALF_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(HIST);
  localparam int STEP_W = $clog2(SUM_W + 1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_START = 8'b0000_0010,
    ST_SUM   = 8'b0000_0100,
    ST_ABS   = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_FIN   = 8'b0010_0000,
    ST_OUT   = 8'b0100_0000,
    ST_NEXT  = 8'b1000_0000
  } state_t;

  // Control state.
  state_t            st_r, st_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              flush_r, flush_nxt;
  logic [H_W-1:0]    h_r, h_nxt;

  // Datapath state.
  logic signed [SAMPLE_BITS-1:0] hist_r [HIST];
  logic [IDX_W-1:0]              k_r, k_nxt;
  logic                          last_r, last_nxt;
  logic [IDX_W-1:0]              q_r, q_nxt;
  logic [IDX_W-1:0]              lim_r, lim_nxt;
  logic                          flag_r, flag_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic signed [SUM_W-1:0]       acc_r, acc_nxt;
  logic                          neg_r, neg_nxt;
  logic [SUM_W-1:0]              quo_r, quo_nxt;
  logic [CNT_W-1:0]              rem_r, rem_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  out_req_t                      out_req_r, out_req_nxt;

  // Helper terms.
  logic                 in_accept;
  logic [IDX_W-1:0]     hw_ext;
  logic [IDX_W-1:0]     two_h;
  logic [IDX_W-1:0]     h_m1;
  logic [IDX_W-1:0]     lim_first;
  logic [IDX_W-1:0]     q_init;
  logic [IDX_W-1:0]     q_cand;
  logic [IDX_W-1:0]     sum_qh;
  logic [IDX_W-1:0]     lim_flush;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W:0]       trial;
  logic                 trial_ge;
  logic [SUM_W-1:0]     quo_signed;

  assign in_stall  = (st_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (st_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  // Window geometry. The first result of a request covers offsets 0..lim
  // from the newest sample; a flushed position q (offset of its centre from
  // the newest sample) covers offsets 0..min(q+h, k).
  assign hw_ext    = IDX_W'(h_r);
  assign two_h     = hw_ext << 1;
  assign h_m1      = hw_ext - IDX_W'(1);
  assign lim_first = (k_r < two_h) ? k_r : two_h;
  assign q_init    = (k_r < h_m1) ? k_r : h_m1;
  assign q_cand    = (st_r == ST_NEXT && flush_r) ? (q_r - IDX_W'(1)) : q_init;
  assign sum_qh    = q_cand + hw_ext;
  assign lim_flush = (sum_qh < k_r) ? sum_qh : k_r;

  // One step of the restoring divider; the divisor is the window count.
  assign dvs        = CNT_W'(lim_r) + CNT_W'(1);
  assign trial      = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge   = (trial >= {1'b0, dvs});
  assign quo_signed = neg_r ? (SUM_W'(0) - quo_r) : quo_r;

  always_comb begin
    st_nxt        = st_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r;
    flush_nxt     = flush_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    q_nxt         = q_r;
    lim_nxt       = lim_r;
    flag_nxt      = flag_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_req_nxt   = out_req_r;

    if (cfg_valid && cfg_ready) begin
      h_nxt = (int'(cfg_data) > MAX_HALF_WINDOW) ? H_W'(MAX_HALF_WINDOW) : H_W'(cfg_data);
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_accept) begin
          last_nxt = in_req.is_last;
          // Offset of the series start, saturated at the oldest history position.
          if (seen_r < CNT_W'(HIST)) begin
            k_nxt    = seen_r[IDX_W-1:0];
            seen_nxt = seen_r + CNT_W'(1);
          end else begin
            k_nxt = IDX_W'(HIST - 1);
          end
          st_nxt = ST_START;
        end
      end
      ST_START: begin
        if (k_r >= hw_ext) begin
          lim_nxt   = lim_first;
          flag_nxt  = last_r && (h_r == '0);
          flush_nxt = 1'b0;
          acc_nxt   = '0;
          idx_nxt   = '0;
          st_nxt    = ST_SUM;
        end else if (last_r) begin
          flush_nxt = 1'b1;
          q_nxt     = q_cand;
          lim_nxt   = lim_flush;
          flag_nxt  = (q_cand == '0);
          acc_nxt   = '0;
          idx_nxt   = '0;
          st_nxt    = ST_SUM;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        acc_nxt = acc_r + SUM_W'(hist_r[idx_r]);
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == lim_r) begin
          st_nxt = ST_ABS;
        end
      end
      ST_ABS: begin
        neg_nxt  = acc_r[SUM_W-1];
        quo_nxt  = acc_r[SUM_W-1] ? (SUM_W'(0) - SUM_W'(acc_r)) : SUM_W'(acc_r);
        rem_nxt  = '0;
        step_nxt = STEP_W'(SUM_W);
        st_nxt   = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = trial_ge ? CNT_W'(trial - {1'b0, dvs}) : CNT_W'(trial);
        quo_nxt  = {quo_r[SUM_W-2:0], trial_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        out_req_nxt.mean     = quo_signed[SAMPLE_BITS-1:0];
        out_req_nxt.out_last = flag_r;
        out_valid_nxt        = 1'b1;
        st_nxt               = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          st_nxt        = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if ((!flush_r && last_r && h_r != '0) || (flush_r && q_r != '0)) begin
          flush_nxt = 1'b1;
          q_nxt     = q_cand;
          lim_nxt   = lim_flush;
          flag_nxt  = (q_cand == '0);
          acc_nxt   = '0;
          idx_nxt   = '0;
          st_nxt    = ST_SUM;
        end else begin
          // The series ends here when this request carried the last flag.
          if (last_r) begin
            seen_nxt = '0;
          end
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      flush_r     <= 1'b0;
      h_r         <= '0;
    end else begin
      st_r        <= st_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      flush_r     <= flush_nxt;
      h_r         <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    last_r    <= last_nxt;
    q_r       <= q_nxt;
    lim_r     <= lim_nxt;
    flag_r    <= flag_nxt;
    idx_r     <= idx_nxt;
    acc_r     <= acc_nxt;
    neg_r     <= neg_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    step_r    <= step_nxt;
    out_req_r <= out_req_nxt;
  end

  // Sample history, newest first; it shifts once per accepted request.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      hist_r[0] <= in_req.sample;
      for (int i = 1; i < HIST; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // A result is only presented while the sequencer waits on the handshake.
  `CMA_ASSERT_NOW(a_out_in_out_state, out_valid, st_r == ST_OUT)
  // The summing pass never reads past the window it was set up for.
  `CMA_ASSERT_NOW(a_sum_in_window, st_r == ST_SUM, idx_r <= lim_r)
  // The series sample count saturates at the history depth.
  `CMA_ASSERT_NOW(a_seen_bounded, 1'b1, seen_r <= CNT_W'(HIST))
  // Only a request that ends the series can produce a final result.
  `CMA_ASSERT_NOW(a_last_only_on_flush, out_valid && out_req.out_last, last_r)

endmodule

`default_nettype wire
